// ===== src/vlcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vlcc_pkg;

   // field and register widths
   localparam int DATA_W    = 16;
   localparam int OFFSET_W  = 6;
   localparam int COPY_W    = 16;
   localparam int HDR_W     = 64;
   localparam int CSR_IDX_W = 1;

   // default build
   localparam int DEF_LINE_BYTES   = 64;
   localparam int DEF_VERSION_BITS = 16;

   // bytes carried by one halfword, shortest legal transfer
   localparam int HW_BYTES  = 2;
   localparam int MIN_BYTES = 8;
   // halfwords that make up the header
   localparam int HDR_HW    = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COPY_BYTES   = 1'd1;

   // register reset values
   localparam logic [OFFSET_W-1:0] RST_START_OFFSET = 6'd0;
   localparam logic [COPY_W-1:0]   RST_COPY_BYTES   = 16'd64;

   // one step's outcome, engine to top level
   typedef struct packed {
      logic              emit;
      logic [DATA_W-1:0] obj_halfword;
      logic              data_valid;
      logic              transfer_done;
      logic              consistent;
   } result_type;

endpackage

`default_nettype wire

// ===== src/vlcc_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vlcc_engine #(
   parameter int LINE_BYTES   = vlcc_pkg::DEF_LINE_BYTES,
   parameter int VERSION_BITS = vlcc_pkg::DEF_VERSION_BITS,
   parameter int SEG_W        = $clog2(LINE_BYTES + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [vlcc_pkg::DATA_W-1:0]   hw,
   input  wire logic [SEG_W-1:0]              seg_init,
   input  wire logic [vlcc_pkg::COPY_W-1:0]   left_init,
   output vlcc_pkg::result_type               result
);

   localparam int LINE_HW = LINE_BYTES / vlcc_pkg::HW_BYTES;
   localparam int LP_W    = $clog2(LINE_HW);
   localparam int VER_HW  = (VERSION_BITS + vlcc_pkg::DATA_W - 1) / vlcc_pkg::DATA_W;
   localparam int VA_W    = VER_HW * vlcc_pkg::DATA_W;
   localparam int HC_W    = $clog2(vlcc_pkg::HDR_HW + 1);
   localparam int HW_W    = vlcc_pkg::DATA_W;
   localparam int HDR_W   = vlcc_pkg::HDR_W;
   localparam int COPY_W  = vlcc_pkg::COPY_W;

   logic                    busy_ff, busy_in;
   logic [COPY_W-1:0]       left_ff, left_in;
   logic [SEG_W-1:0]        seg_ff, seg_in;
   logic [LP_W-1:0]         lp_ff, lp_in;
   logic                    first_ff, first_in;
   logic [HDR_W-1:0]        hdr_ff, hdr_in;
   logic [HC_W-1:0]         hcnt_ff, hcnt_in;
   logic [VERSION_BITS-1:0] ver_ff, ver_in;
   logic [VA_W-1:0]         acc_ff, acc_in;
   logic                    abort_ff, abort_in;

   // effective state: an idle block starts a fresh transfer
   logic [COPY_W-1:0] s_left;
   logic [SEG_W-1:0]  s_seg;
   logic [LP_W-1:0]   s_lp;
   logic              s_first;
   logic [HDR_W-1:0]  s_hdr;
   logic [HC_W-1:0]   s_hcnt;
   logic              s_abort;

   always_comb begin
      s_left  = busy_ff ? left_ff  : left_init;
      s_seg   = busy_ff ? seg_ff   : seg_init;
      s_lp    = busy_ff ? lp_ff    : '0;
      s_first = busy_ff ? first_ff : 1'b1;
      s_hdr   = busy_ff ? hdr_ff   : '0;
      s_hcnt  = busy_ff ? hcnt_ff  : '0;
      s_abort = busy_ff ? abort_ff : 1'b0;
   end

   // per-request state update and result
   always_comb begin
      busy_in  = 1'b1;
      left_in  = s_left;
      seg_in   = s_seg;
      lp_in    = s_lp;
      first_in = s_first;
      hdr_in   = s_hdr;
      hcnt_in  = s_hcnt;
      ver_in   = ver_ff;
      acc_in   = acc_ff;
      abort_in = s_abort;
      result   = '0;

      if (s_first) begin
         // raw first segment, header captured from its leading halfwords
         if (s_hcnt < HC_W'(vlcc_pkg::HDR_HW)) begin
            hdr_in  = {s_hdr[HDR_W-HW_W-1:0], hw};
            hcnt_in = s_hcnt + HC_W'(1);
         end
         seg_in = s_seg - SEG_W'(vlcc_pkg::HW_BYTES);
         result.emit         = 1'b1;
         result.obj_halfword = hw;
         result.data_valid   = 1'b1;
         if (seg_in == '0) begin
            first_in = 1'b0;
            lp_in    = '0;
            ver_in   = hdr_in[VERSION_BITS+1:2];
            if (hdr_in[1]) begin
               // writer was updating: end the transfer, drop the rest
               abort_in             = 1'b1;
               busy_in              = (s_left != '0);
               result.transfer_done = 1'b1;
            end else if (s_left == '0) begin
               busy_in              = 1'b0;
               result.transfer_done = 1'b1;
               result.consistent    = 1'b1;
            end
         end
      end else if (s_lp < LP_W'(VER_HW)) begin
         // version word at the head of a line: check and strip
         acc_in = (s_lp == '0) ? VA_W'(hw) : VA_W'({acc_ff, hw});
         lp_in  = s_lp + LP_W'(1);
         if (lp_in == LP_W'(VER_HW) && !s_abort &&
             acc_in[VERSION_BITS-1:0] != ver_ff) begin
            abort_in             = 1'b1;
            result.emit          = 1'b1;
            result.transfer_done = 1'b1;
         end
      end else begin
         // object data within a line
         left_in = s_left - COPY_W'(vlcc_pkg::HW_BYTES);
         lp_in   = (s_lp == LP_W'(LINE_HW - 1)) ? '0 : s_lp + LP_W'(1);
         if (!s_abort) begin
            result.emit         = 1'b1;
            result.obj_halfword = hw;
            result.data_valid   = 1'b1;
         end
         if (left_in == '0) begin
            busy_in = 1'b0;
            if (!s_abort) begin
               result.transfer_done = 1'b1;
               result.consistent    = 1'b1;
            end
         end
      end
   end

   // advance the transfer state on each request
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         left_ff  <= '0;
         seg_ff   <= '0;
         lp_ff    <= '0;
         first_ff <= 1'b1;
         hdr_ff   <= '0;
         hcnt_ff  <= '0;
         ver_ff   <= '0;
         acc_ff   <= '0;
         abort_ff <= 1'b0;
      end else if (step) begin
         busy_ff  <= busy_in;
         left_ff  <= left_in;
         seg_ff   <= seg_in;
         lp_ff    <= lp_in;
         first_ff <= first_in;
         hdr_ff   <= hdr_in;
         hcnt_ff  <= hcnt_in;
         ver_ff   <= ver_in;
         acc_ff   <= acc_in;
         abort_ff <= abort_in;
      end
   end

   // a result without data only ever reports a failed check
   assert property (@(posedge clock) disable iff (reset)
      step && result.emit && !result.data_valid |->
         result.transfer_done && !result.consistent)
      else $error("dataless result that is not a failure report");

   // a good end always closes the transfer
   assert property (@(posedge clock) disable iff (reset)
      step && result.transfer_done && result.consistent |=> !busy_ff)
      else $error("transfer still busy after a consistent end");

   // an open first segment always has bytes left in it
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && first_ff |-> seg_ff != '0)
      else $error("first segment open with nothing left");

   // nothing is produced after an abort except while still in the first segment
   assert property (@(posedge clock) disable iff (reset)
      step && busy_ff && abort_ff && !first_ff |-> !result.emit)
      else $error("result produced after abort");

endmodule

`default_nettype wire

// ===== src/versioned_line_copy_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Versioned line copy checker.
// Requests carry the halfwords of a remotely read object buffer in buffer
// order (req_valid/req_ready). The first request after idle starts a
// transfer, sampling start_offset and copy_bytes; the first segment is passed
// through and its first four halfwords form the header. Each later line
// begins with a version word that is checked and stripped.
// Results leave on rsp_valid/rsp_ready; a request yields zero or one result.
// Version words produce none unless their check fails; the remainder of an aborted transfer produces none.
// An accepted request waits in the input register until the engine takes
// it; the per-request logic writes its result into the result register.
// Throughput: one request per cycle while the receiver does not stall.
// When the receiver stalls the result register holds, the input register
// fills, and req_ready drops until rsp_ready returns.
// Configuration writes (csr_we, csr_index, csr_wdata) are for the user to
// make only between transfers; the block itself does not enforce this.
// Reset clears the transfer state, sets start_offset to 0 and copy_bytes
// to 64, and empties both registers.

module versioned_line_copy_checker #(
   parameter int LINE_BYTES   = vlcc_pkg::DEF_LINE_BYTES,
   parameter int VERSION_BITS = vlcc_pkg::DEF_VERSION_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [vlcc_pkg::DATA_W-1:0]       req_src_halfword,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [vlcc_pkg::DATA_W-1:0]            rsp_obj_halfword,
   output logic                                   rsp_data_valid,
   output logic                                   rsp_transfer_done,
   output logic                                   rsp_consistent,
   input  wire logic                              csr_we,
   input  wire logic [vlcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [vlcc_pkg::COPY_W-1:0]       csr_wdata
);

   localparam int SEG_W  = $clog2(LINE_BYTES + 1);
   localparam int COPY_W = vlcc_pkg::COPY_W;
   localparam int OFF_W  = vlcc_pkg::OFFSET_W;

   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [COPY_W-1:0] copy_ff, copy_in;
   logic [SEG_W-1:0]  seg_init_ff;
   logic [COPY_W-1:0] left_init_ff;
   logic [OFF_W-1:0]  cfg_off;
   logic [COPY_W-1:0] cfg_copy;
   logic [COPY_W-1:0] calc_off, calc_seg, calc_total;

   // register writes
   always_comb begin
      offset_in = offset_ff;
      copy_in   = copy_ff;
      if (csr_we) begin
         case (csr_index)
            vlcc_pkg::CSR_START_OFFSET: offset_in = csr_wdata[OFF_W-1:0];
            vlcc_pkg::CSR_COPY_BYTES:   copy_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // first segment length and remaining bytes, prepared when config changes
   always_comb begin
      cfg_off  = reset ? vlcc_pkg::RST_START_OFFSET : offset_in;
      cfg_copy = reset ? vlcc_pkg::RST_COPY_BYTES   : copy_in;
      calc_off = COPY_W'({cfg_off[OFF_W-1:3], 3'b000});
      for (int i = 0; i < 4; i++) begin
         if (calc_off >= COPY_W'(LINE_BYTES)) calc_off = calc_off - COPY_W'(LINE_BYTES);
      end
      calc_seg   = COPY_W'(LINE_BYTES) - calc_off;
      calc_total = {cfg_copy[COPY_W-1:1], 1'b0};
      if (calc_total < COPY_W'(vlcc_pkg::MIN_BYTES)) calc_total = COPY_W'(vlcc_pkg::MIN_BYTES);
      if (calc_seg < COPY_W'(vlcc_pkg::MIN_BYTES)) calc_seg = COPY_W'(vlcc_pkg::MIN_BYTES);
      if (calc_seg > calc_total) calc_seg = calc_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= vlcc_pkg::RST_START_OFFSET;
         copy_ff   <= vlcc_pkg::RST_COPY_BYTES;
      end else begin
         offset_ff <= offset_in;
         copy_ff   <= copy_in;
      end
      seg_init_ff  <= calc_seg[SEG_W-1:0];
      left_init_ff <= calc_total - calc_seg;
   end

   // input register and result register
   logic                          in_valid_ff;
   logic [vlcc_pkg::DATA_W-1:0]   in_hw_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vlcc_pkg::DATA_W-1:0]   rsp_hw_ff;
   logic                          rsp_dv_ff, rsp_done_ff, rsp_ok_ff;
   logic                          out_free, step;
   vlcc_pkg::result_type          result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   vlcc_engine #(
      .LINE_BYTES   (LINE_BYTES),
      .VERSION_BITS (VERSION_BITS),
      .SEG_W        (SEG_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .hw        (in_hw_ff),
      .seg_init  (seg_init_ff),
      .left_init (left_init_ff),
      .result    (result)
   );

   assign rsp_valid_in = step ? result.emit : (rsp_valid_ff && !rsp_ready);

   // hold the request until the engine takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) in_valid_ff <= 1'b1;
         else if (step)              in_valid_ff <= 1'b0;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && req_ready) in_hw_ff <= req_src_halfword;
      if (step && result.emit) begin
         rsp_hw_ff   <= result.obj_halfword;
         rsp_dv_ff   <= result.data_valid;
         rsp_done_ff <= result.transfer_done;
         rsp_ok_ff   <= result.consistent;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_obj_halfword  = rsp_hw_ff;
   assign rsp_data_valid    = rsp_dv_ff;
   assign rsp_transfer_done = rsp_done_ff;
   assign rsp_consistent    = rsp_ok_ff;

endmodule

`default_nettype wire

// ===== tb/tb_versioned_line_copy_checker.sv =====
`timescale 1ns / 1ps

module tb_versioned_line_copy_checker;

   localparam int LINE_B        = vlcc_pkg::DEF_LINE_BYTES;
   localparam int VER_BITS      = vlcc_pkg::DEF_VERSION_BITS;
   localparam int LINE_HW       = LINE_B / 2;
   localparam int VER_HW        = (VER_BITS + 15) / 16;
   localparam int LINE_PAYLOAD  = LINE_B - vlcc_pkg::HW_BYTES * VER_HW;
   localparam logic [31:0] VER_MASK = 32'((64'd1 << VER_BITS) - 64'd1);
   localparam int RANDOM_REQUESTS = 880;
   localparam int IDLE_SETTLE     = 6;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_LEN    = 250;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      logic [vlcc_pkg::DATA_W-1:0] obj_halfword;
      logic                        data_valid;
      logic                        transfer_done;
      logic                        consistent;
   } obj_result_type;

   typedef enum int {COPY_GOOD, COPY_UPDATING, COPY_TORN, COPY_NOISE} copy_kind_type;
   typedef enum int {RX_STEADY, RX_COIN, RX_LIGHT, RX_SPARSE} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [vlcc_pkg::DATA_W-1:0] req_src_halfword = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [vlcc_pkg::DATA_W-1:0] rsp_obj_halfword;
   logic rsp_data_valid;
   logic rsp_transfer_done;
   logic rsp_consistent;
   logic csr_we = 1'b0;
   logic [vlcc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [vlcc_pkg::COPY_W-1:0] csr_wdata = '0;

   // register copies used when a copy starts
   logic [vlcc_pkg::OFFSET_W-1:0] cfg_start_offset = vlcc_pkg::RST_START_OFFSET;
   logic [vlcc_pkg::COPY_W-1:0]   cfg_copy_bytes   = vlcc_pkg::RST_COPY_BYTES;

   // copy tracking state
   bit          copy_active = 1'b0;
   int unsigned seg_bytes_left = 0;
   int unsigned obj_bytes_left = 0;
   int unsigned line_hw_pos = 0;
   bit          in_lead_segment = 1'b1;
   logic [vlcc_pkg::HDR_W-1:0] header_word = '0;
   int unsigned header_words_seen = 0;
   logic [31:0] want_version = '0;
   logic [31:0] version_word = '0;
   bit          copy_dropped = 1'b0;

   obj_result_type expected_results[$];

   int mismatch_count = 0;
   int requests_accepted = 0;
   int results_checked = 0;
   int copies_started = 0;
   int copies_inconsistent = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int hold_off_cycles = 0;

   versioned_line_copy_checker u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_src_halfword  (req_src_halfword),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_obj_halfword  (rsp_obj_halfword),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_consistent    (rsp_consistent),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // split the current copy length into lead segment and remainder bytes
   function automatic void copy_layout(output int unsigned seg, output int unsigned rest);
      int unsigned total;
      int unsigned off;
      total = cfg_copy_bytes & 16'hFFFE;
      if (total < vlcc_pkg::MIN_BYTES) total = vlcc_pkg::MIN_BYTES;
      off = (cfg_start_offset & 6'h38) % LINE_B;
      seg = LINE_B - off;
      if (seg < vlcc_pkg::MIN_BYTES) seg = vlcc_pkg::MIN_BYTES;
      if (seg > total) seg = total;
      rest = total - seg;
   endfunction

   // advance the copy state by one source halfword and queue its result
   function automatic void predict_copy_step(input logic [vlcc_pkg::DATA_W-1:0] hw);
      obj_result_type r;
      bit emit;
      r = '0;
      emit = 1'b0;
      if (!copy_active) begin
         copy_layout(seg_bytes_left, obj_bytes_left);
         line_hw_pos = 0;
         in_lead_segment = 1'b1;
         header_word = '0;
         header_words_seen = 0;
         want_version = '0;
         version_word = '0;
         copy_dropped = 1'b0;
         copy_active = 1'b1;
         copies_started++;
      end
      if (in_lead_segment) begin
         if (header_words_seen < vlcc_pkg::HDR_HW) begin
            header_word = {header_word[vlcc_pkg::HDR_W-vlcc_pkg::DATA_W-1:0], hw};
            header_words_seen++;
         end
         seg_bytes_left -= vlcc_pkg::HW_BYTES;
         emit = 1'b1;
         r = '{hw, 1'b1, 1'b0, 1'b0};
         if (seg_bytes_left == 0) begin
            in_lead_segment = 1'b0;
            line_hw_pos = 0;
            want_version = 32'(header_word >> 2) & VER_MASK;
            if (header_word[1]) begin
               copy_dropped = 1'b1;
               if (obj_bytes_left == 0) copy_active = 1'b0;
               r.transfer_done = 1'b1;
            end else if (obj_bytes_left == 0) begin
               copy_active = 1'b0;
               r.transfer_done = 1'b1;
               r.consistent = 1'b1;
            end
         end
      end else if (line_hw_pos < VER_HW) begin
         version_word = (line_hw_pos == 0) ? 32'(hw) : {version_word[15:0], hw};
         line_hw_pos++;
         if (line_hw_pos == VER_HW && !copy_dropped &&
             (version_word & VER_MASK) != want_version) begin
            copy_dropped = 1'b1;
            emit = 1'b1;
            r = '{'0, 1'b0, 1'b1, 1'b0};
         end
      end else begin
         obj_bytes_left -= vlcc_pkg::HW_BYTES;
         line_hw_pos++;
         if (line_hw_pos >= LINE_HW) line_hw_pos = 0;
         if (obj_bytes_left == 0) copy_active = 1'b0;
         if (!copy_dropped) begin
            emit = 1'b1;
            r = '{hw, 1'b1, obj_bytes_left == 0, obj_bytes_left == 0};
         end
      end
      if (emit) begin
         if (r.transfer_done && !r.consistent) copies_inconsistent++;
         expected_results.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // predict on accepted requests, then check accepted results
   always @(posedge clock) begin : result_monitor
      obj_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            requests_accepted++;
            predict_copy_step(req_src_halfword);
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing expected: hw %h v%b d%b c%b",
                  results_checked, rsp_obj_halfword, rsp_data_valid, rsp_transfer_done,
                  rsp_consistent));
            end else begin
               want = expected_results.pop_front();
               if (rsp_obj_halfword !== want.obj_halfword)
                  report_mismatch($sformatf("result %0d obj_halfword %h, want %h",
                     results_checked, rsp_obj_halfword, want.obj_halfword));
               if (rsp_data_valid !== want.data_valid)
                  report_mismatch($sformatf("result %0d data_valid %b, want %b",
                     results_checked, rsp_data_valid, want.data_valid));
               if (rsp_transfer_done !== want.transfer_done)
                  report_mismatch($sformatf("result %0d transfer_done %b, want %b",
                     results_checked, rsp_transfer_done, want.transfer_done));
               if (rsp_consistent !== want.consistent)
                  report_mismatch($sformatf("result %0d consistent %b, want %b",
                     results_checked, rsp_consistent, want.consistent));
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no request or result accepted for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   // receiver: stall on changing patterns, hold off on demand
   initial begin : receiver
      rx_mode_type mode;
      int mode_left;
      int phase;
      mode = RX_STEADY;
      mode_left = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(RX_STEADY, RX_SPARSE));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_LIGHT:  rsp_ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_ready <= (phase % 4 == 0);
         endcase
      end
   end

   // offer one request, with bursts and gaps, and hold it until accepted
   task automatic send_halfword(input logic [vlcc_pkg::DATA_W-1:0] hw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_src_halfword <= hw;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until the block has nothing left to do
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (copy_active || expected_results.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic configure_copy(input logic [vlcc_pkg::COPY_W-1:0] offset_word,
                                 input logic [vlcc_pkg::COPY_W-1:0] copy_len);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= vlcc_pkg::CSR_START_OFFSET;
      csr_wdata <= offset_word;
      cfg_start_offset = offset_word[vlcc_pkg::OFFSET_W-1:0];
      @(negedge clock);
      csr_index <= vlcc_pkg::CSR_COPY_BYTES;
      csr_wdata <= copy_len;
      cfg_copy_bytes = copy_len;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // send one buffer laid out for the current registers
   task automatic send_copy(input copy_kind_type kind);
      int unsigned seg_bytes;
      int unsigned rest_bytes;
      int unsigned lines;
      int unsigned bad_line;
      int unsigned chunk;
      logic [vlcc_pkg::DATA_W-1:0] version;
      logic [vlcc_pkg::DATA_W-1:0] flip;
      logic [vlcc_pkg::DATA_W-1:0] word;
      copy_layout(seg_bytes, rest_bytes);
      lines = (rest_bytes + LINE_PAYLOAD - 1) / LINE_PAYLOAD;
      bad_line = (lines != 0) ? $urandom_range(0, lines - 1) : 0;
      version = 16'($urandom);
      flip = ($urandom_range(0, 1) != 0) ? (16'h1 << $urandom_range(0, 15))
                                         : 16'($urandom_range(1, 16'hFFFF));
      // lead segment with the header in its first four halfwords
      for (int i = 0; i < seg_bytes / vlcc_pkg::HW_BYTES; i++) begin
         word = 16'($urandom);
         if (kind != COPY_NOISE) begin
            if (i == 2) word[1:0] = version[15:14];
            if (i == 3) begin
               word[15:2] = version[13:0];
               word[1] = (kind == COPY_UPDATING);
            end
         end
         send_halfword(word);
      end
      // later lines: version word then payload
      for (int ln = 0; ln < lines; ln++) begin
         if (kind == COPY_NOISE) word = 16'($urandom);
         else if (kind == COPY_TORN && ln == bad_line) word = version ^ flip;
         else word = version;
         send_halfword(word);
         chunk = (rest_bytes > LINE_PAYLOAD) ? LINE_PAYLOAD : rest_bytes;
         rest_bytes -= chunk;
         for (int k = 0; k < chunk / vlcc_pkg::HW_BYTES; k++) send_halfword(16'($urandom));
      end
   endtask

   // lengths below eight, all-zero and all-ones payloads
   task automatic test_short_copies();
      configure_copy(16'd0, 16'd0);
      repeat (vlcc_pkg::HDR_HW) send_halfword(16'h0000);
      configure_copy(16'd0, 16'd7);
      repeat (vlcc_pkg::HDR_HW) send_halfword(16'hFFFF);
   endtask

   // last slot of a line, odd length
   task automatic test_offset_extremes();
      configure_copy(16'd56, 16'd13);
      send_copy(COPY_GOOD);
   endtask

   // unaligned offset with a bad version word and a dropped tail
   task automatic test_torn_version();
      configure_copy(16'd63, 16'd16);
      send_copy(COPY_TORN);
   endtask

   // several full lines and a partial last line, odd length
   task automatic test_multi_line_copy();
      configure_copy(16'd0, 16'd257);
      send_copy(COPY_GOOD);
   endtask

   // hold the receiver off so the block fills and stalls its input
   task automatic test_output_backpressure();
      configure_copy(16'd0, 16'd400);
      hold_off_cycles = HOLD_OFF_LEN;
      send_copy(COPY_GOOD);
   endtask

   task automatic test_random_copies();
      int first_request;
      int pick;
      logic [vlcc_pkg::COPY_W-1:0] offset_word;
      logic [vlcc_pkg::COPY_W-1:0] copy_len;
      first_request = requests_accepted;
      while (requests_accepted - first_request < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 2) != 0) begin
            offset_word = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                        : 16'($urandom_range(0, 7) * 8);
            pick = $urandom_range(0, 19);
            if (pick < 2) copy_len = 16'($urandom_range(0, 15));
            else if (pick < 15) copy_len = 16'($urandom_range(16, 160));
            else copy_len = 16'($urandom_range(161, 700));
            configure_copy(offset_word, copy_len);
         end
         pick = $urandom_range(0, 19);
         if (pick < 2) send_copy(COPY_UPDATING);
         else if (pick < 5) send_copy(COPY_TORN);
         else if (pick < 6) send_copy(COPY_NOISE);
         else send_copy(COPY_GOOD);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_short_copies();
      test_offset_extremes();
      test_torn_version();
      test_multi_line_copy();
      test_output_backpressure();
      test_random_copies();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d copies, %0d requests, %0d results (%0d ended inconsistent)",
         copies_started, requests_accepted, results_checked, copies_inconsistent);
      $display("offsets 0..63, lengths 0..700, random stalls and a long receiver hold-off");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/vlcc_pkg.sv
src/vlcc_engine.sv
src/versioned_line_copy_checker.sv
tb/tb_versioned_line_copy_checker.sv
